FILE: rtl/core/tuc_pkg.sv
// Shared types, codes and helper functions for the thermostat UI controller.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tuc_pkg;

	localparam int LEVEL_COUNT_DEF = 5;
	localparam int BLINK_BIT_DEF   = 4;
	localparam int THR_COUNT       = 5;
	localparam int LED_COUNT       = 5;

	// configuration register indexes
	localparam logic [2:0] REG_THR_A    = 3'd0;
	localparam logic [2:0] REG_THR_B    = 3'd1;
	localparam logic [2:0] REG_THR_C    = 3'd2;
	localparam logic [2:0] REG_THR_D    = 3'd3;
	localparam logic [2:0] REG_THR_E    = 3'd4;
	localparam logic [2:0] REG_LONG     = 3'd5;
	localparam logic [2:0] REG_TIMEOUT  = 3'd6;
	localparam logic [2:0] REG_INIT_LVL = 3'd7;

	// reset values of the registers
	localparam logic [7:0]  THR_A_RST     = 8'd2;
	localparam logic [7:0]  THR_B_RST     = 8'd4;
	localparam logic [7:0]  THR_C_RST     = 8'd6;
	localparam logic [7:0]  THR_D_RST     = 8'd8;
	localparam logic [7:0]  THR_E_RST     = 8'd12;
	localparam logic [14:0] LONG_RST      = 15'd200;
	localparam logic [14:0] TIMEOUT_RST   = 15'd2000;
	localparam logic [2:0]  SET_LEVEL_RST = 3'd2;

	// item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_TEMP = 1'b1;

	// button event codes
	localparam logic [1:0] EVT_NONE    = 2'd0;
	localparam logic [1:0] EVT_LONG    = 2'd1;
	localparam logic [1:0] EVT_RELEASE = 2'd2;

	// mode codes as seen on the result
	localparam logic [1:0] DISP_IDLE    = 2'd0;
	localparam logic [1:0] DISP_MONITOR = 2'd1;
	localparam logic [1:0] DISP_SETTING = 2'd2;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'b001,
		MODE_MONITOR = 3'b010,
		MODE_SETTING = 3'b100
	} mode_t;

	typedef struct packed {
		logic              opcode;
		logic              button_pressed;
		logic signed [7:0] temperature;
	} in_t;

	typedef struct packed {
		logic              heater_on;
		logic [4:0]        led_bar;
		logic [1:0]        ui_mode;
		logic [2:0]        level_set;
		logic signed [3:0] level_current;
		logic              save_request;
		logic [1:0]        button_event;
	} out_t;

	typedef struct packed {
		logic [THR_COUNT-1:0][7:0] thr;
		logic [14:0]               long_ticks;
		logic [14:0]               timeout_ticks;
		logic                      load_level;
		logic [2:0]                level_value;
	} cfg_t;

	// elapsed time as signed 16 bit; negative never exceeds
	function automatic logic exceeds(logic [15:0] now, logic [15:0] stamp,
			logic [14:0] limit);
		logic [15:0] d;
		d = now - stamp;
		return !d[15] && (d[14:0] > limit);
	endfunction

	// LEDs 0..lvl lit, clipped to the bar
	function automatic logic [LED_COUNT-1:0] bar_for(logic [2:0] lvl);
		logic [LED_COUNT-1:0] b;
		for (int i = 0; i < LED_COUNT; i++) begin
			b[i] = (3'(i) <= lvl);
		end
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tuc_cfg_regs.sv
// Configuration register file: thresholds, press and timeout limits.
// Emits a combinational load strobe when a valid initial level is written. Uses tuc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tuc_cfg_regs #(
	parameter int LEVEL_COUNT = tuc_pkg::LEVEL_COUNT_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               wr_valid,
	input  wire  [2:0]        cfg_index,
	input  wire  [14:0]       cfg_data,
	output tuc_pkg::cfg_t     cfg
);
	import tuc_pkg::*;

	logic [THR_COUNT-1:0][7:0] thr_q;
	logic [14:0]               long_q;
	logic [14:0]               timeout_q;
	logic                      we;

	assign we = wr_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q[0]  <= THR_A_RST;
			thr_q[1]  <= THR_B_RST;
			thr_q[2]  <= THR_C_RST;
			thr_q[3]  <= THR_D_RST;
			thr_q[4]  <= THR_E_RST;
			long_q    <= LONG_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (we) begin
			unique case (cfg_index)
				REG_THR_A:    thr_q[0]  <= cfg_data[7:0];
				REG_THR_B:    thr_q[1]  <= cfg_data[7:0];
				REG_THR_C:    thr_q[2]  <= cfg_data[7:0];
				REG_THR_D:    thr_q[3]  <= cfg_data[7:0];
				REG_THR_E:    thr_q[4]  <= cfg_data[7:0];
				REG_LONG:     long_q    <= cfg_data;
				REG_TIMEOUT:  timeout_q <= cfg_data;
				REG_INIT_LVL: ;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.thr           = thr_q;
		cfg.long_ticks    = long_q;
		cfg.timeout_ticks = timeout_q;
		cfg.level_value   = cfg_data[2:0];
		// out-of-range levels are accepted but do not load the set level
		cfg.load_level    = we && (cfg_index == REG_INIT_LVL) &&
			({1'b0, cfg_data[2:0]} < 4'(LEVEL_COUNT));
	end

endmodule

`default_nettype wire

FILE: rtl/core/tuc_button.sv
// Button hold-off history and press tracker: long press and short release events.
// Updated once per tick request. Uses tuc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tuc_button (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         step,
	input  wire         pressed,
	input  wire  [15:0] now,
	input  wire  [14:0] long_ticks,
	output logic [1:0]  evt
);
	import tuc_pkg::*;

	logic [7:0]  hist_q;
	logic [15:0] stamp_q;
	logic [1:0]  latched_q;
	logic [7:0]  hist_n;
	logic [15:0] stamp_n;
	logic [1:0]  latched_n;
	logic        was;

	always_comb begin
		was       = (hist_q != 8'd0);
		hist_n    = {hist_q[6:0], pressed};
		stamp_n   = stamp_q;
		latched_n = latched_q;
		evt       = EVT_NONE;
		if (hist_n != 8'd0) begin
			if (!was) begin
				stamp_n   = now;
				latched_n = EVT_NONE;
			end else if (latched_q == EVT_NONE && exceeds(now, stamp_q, long_ticks)) begin
				latched_n = EVT_LONG;
				evt       = EVT_LONG;
			end
		end else if (was && latched_q == EVT_NONE) begin
			latched_n = EVT_RELEASE;
			evt       = EVT_RELEASE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q    <= 8'd0;
			stamp_q   <= 16'd0;
			latched_q <= EVT_NONE;
		end else if (step) begin
			hist_q    <= hist_n;
			stamp_q   <= stamp_n;
			latched_q <= latched_n;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/tuc_level.sv
// Temperature to level mapping against the ascending threshold set.
// Pure compare logic. Uses tuc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tuc_level #(
	parameter int LEVEL_COUNT = tuc_pkg::LEVEL_COUNT_DEF
) (
	input  wire  signed [7:0]                  temperature,
	input  wire  [tuc_pkg::THR_COUNT-1:0][7:0] thr,
	output logic signed [3:0]                  level
);
	import tuc_pkg::*;

	logic [LEVEL_COUNT-1:0] below;

	always_comb begin
		// levels past the last threshold reuse the highest one
		for (int i = 0; i < LEVEL_COUNT; i++) begin
			below[i] = temperature <
				$signed(thr[(i < THR_COUNT) ? i : THR_COUNT - 1]);
		end
		level = 4'(LEVEL_COUNT - 1);
		for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
			if (below[i]) begin
				level = 4'(i - 1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/thermostat_ui_controller.sv
// Thermostat UI controller: button events, LED bar, mode machine and heater.
// Path: an accepted request waits in the input register, then moves to the result
// register, which raises out_valid; a stalled result holds it in the input register.
// Throughput: one request per cycle barring out_stall; item logic is a single pass between the two.
// Reset (arst_n low, asynchronous): clock, history and stamps zero, idle mode,
// set level 2, heater off, bar dark, registers at their defaults. No clearing pass.
// Depends on tuc_pkg, tuc_cfg_regs, tuc_button, tuc_level.
`timescale 1ns / 1ps
`default_nettype none

module thermostat_ui_controller #(
	parameter int LEVEL_COUNT = tuc_pkg::LEVEL_COUNT_DEF,
	parameter int BLINK_BIT   = tuc_pkg::BLINK_BIT_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire tuc_pkg::in_t in_item,
	output logic              out_valid,
	input  wire               out_stall,
	output tuc_pkg::out_t     out_item,
	input  wire               wr_valid,
	output logic              cfg_ready,
	input  wire  [2:0]        cfg_index,
	input  wire  [14:0]       cfg_data
);
	import tuc_pkg::*;

	cfg_t        cfg;
	logic        valid_s1;
	in_t         item_s1;
	logic        advance;
	logic        is_tick;

	logic [15:0]       tick_q;
	mode_t             mode_q;
	logic [15:0]       mode_stamp_q;
	logic [2:0]        set_level_q;
	logic signed [3:0] cur_level_q;
	logic              heater_q;
	logic [4:0]        bar_q;

	logic [15:0]       tick_n;
	mode_t             mode_mid;
	mode_t             mode_n;
	logic [15:0]       mode_stamp_n;
	logic [2:0]        set_level_n;
	logic signed [3:0] cur_level_n;
	logic              heater_n;
	logic [4:0]        bar_n;
	logic              save;
	logic [1:0]        evt;
	logic [1:0]        evt_raw;
	logic signed [3:0] level_map;
	logic [3:0]        lvl_inc;
	logic [1:0]        ui_code;

	assign cfg_ready = 1'b1;

	tuc_cfg_regs #(.LEVEL_COUNT(LEVEL_COUNT)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_valid  (wr_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register and result register handshake
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign is_tick  = (item_s1.opcode == OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	assign tick_n = tick_q + 16'd1;

	tuc_button u_button (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance && is_tick),
		.pressed    (item_s1.button_pressed),
		.now        (tick_n),
		.long_ticks (cfg.long_ticks),
		.evt        (evt_raw)
	);

	tuc_level #(.LEVEL_COUNT(LEVEL_COUNT)) u_level (
		.temperature (item_s1.temperature),
		.thr         (cfg.thr),
		.level       (level_map)
	);

	// wrap of the set level; the value stays below twice the level count
	always_comb begin
		lvl_inc = {1'b0, set_level_q} + 4'd1;
		if (lvl_inc >= 4'(LEVEL_COUNT)) begin
			lvl_inc = lvl_inc - 4'(LEVEL_COUNT);
		end
	end

	always_comb begin
		mode_mid     = mode_q;
		mode_n       = mode_q;
		mode_stamp_n = mode_stamp_q;
		set_level_n  = set_level_q;
		cur_level_n  = cur_level_q;
		heater_n     = heater_q;
		bar_n        = bar_q;
		save         = 1'b0;
		evt          = EVT_NONE;
		if (is_tick) begin
			evt   = evt_raw;
			bar_n = 5'd0;
			unique case (mode_q)
				MODE_SETTING: begin
					heater_n = 1'b1;
					if (tick_n[BLINK_BIT]) begin
						bar_n = bar_for(set_level_q);
					end
				end
				MODE_MONITOR: begin
					heater_n = 1'b1;
					if (!cur_level_q[3]) begin
						bar_n = bar_for(cur_level_q[2:0]);
					end
				end
				MODE_IDLE: ;
				default: ;
			endcase
			if (mode_q != MODE_IDLE && exceeds(tick_n, mode_stamp_q, cfg.timeout_ticks)) begin
				mode_mid     = MODE_IDLE;
				mode_stamp_n = tick_n;
			end
			mode_n = mode_mid;
			if (evt != EVT_NONE) begin
				mode_stamp_n = tick_n;
				if (mode_mid == MODE_SETTING) begin
					if (evt == EVT_RELEASE) begin
						set_level_n = lvl_inc[2:0];
						mode_n      = MODE_SETTING;
					end else begin
						save   = 1'b1;
						mode_n = MODE_IDLE;
					end
				end else if (evt == EVT_LONG) begin
					mode_n = MODE_SETTING;
				end else begin
					mode_n = (mode_mid == MODE_IDLE) ? MODE_MONITOR : MODE_IDLE;
				end
			end
		end else begin
			cur_level_n = level_map;
			if (mode_q == MODE_IDLE) begin
				heater_n = (level_map < $signed({1'b0, set_level_q}));
			end
		end
	end

	always_comb begin
		unique case (mode_n)
			MODE_IDLE:    ui_code = DISP_IDLE;
			MODE_MONITOR: ui_code = DISP_MONITOR;
			MODE_SETTING: ui_code = DISP_SETTING;
			default:      ui_code = DISP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= 16'd0;
			mode_q       <= MODE_IDLE;
			mode_stamp_q <= 16'd0;
			set_level_q  <= SET_LEVEL_RST;
			cur_level_q  <= 4'sd0;
			heater_q     <= 1'b0;
			bar_q        <= 5'd0;
		end else begin
			if (advance) begin
				if (is_tick) begin
					tick_q <= tick_n;
				end
				mode_q       <= mode_n;
				mode_stamp_q <= mode_stamp_n;
				cur_level_q  <= cur_level_n;
				heater_q     <= heater_n;
				bar_q        <= bar_n;
			end
			// a config load wins; the user must write only while no request is in flight; the block does not enforce it
			if (cfg.load_level) begin
				set_level_q <= cfg.level_value;
			end else if (advance) begin
				set_level_q <= set_level_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item.heater_on     <= heater_n;
			out_item.led_bar       <= bar_n;
			out_item.ui_mode       <= ui_code;
			out_item.level_set     <= set_level_n;
			out_item.level_current <= cur_level_n;
			out_item.save_request  <= save;
			out_item.button_event  <= evt;
		end
	end

endmodule

`default_nettype wire

FILE: tb/thermostat_ui_controller_tb.sv
// Self-checking testbench for thermostat_ui_controller: button events, LED bar,
// mode machine and heater, checked request by request against a local prediction.
// Depends on tuc_pkg and the controller RTL only.
`timescale 1ns / 1ps

module thermostat_ui_controller_tb;
	import tuc_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 125;
	localparam int PHASES       = 10;
	localparam int SOAK_TICKS   = 40;
	localparam int REPORT_LIMIT = 10;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	in_t   in_item = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	out_t  out_item;
	logic  wr_valid = 1'b0;
	logic  cfg_ready;
	logic  [2:0] cfg_index = '0;
	logic  [14:0] cfg_data = '0;

	thermostat_ui_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.wr_valid  (wr_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted controller state and register copy
	logic signed [7:0] thr [THR_COUNT] = '{THR_A_RST, THR_B_RST, THR_C_RST, THR_D_RST, THR_E_RST};
	logic [14:0]       long_ticks    = LONG_RST;
	logic [14:0]       timeout_ticks = TIMEOUT_RST;
	logic [15:0]       tick_cnt      = '0;
	logic [7:0]        hist_pred     = '0;
	logic [15:0]       press_stamp   = '0;
	logic [1:0]        press_latch   = EVT_NONE;
	logic [1:0]        mode_pred     = DISP_IDLE;
	logic [15:0]       mode_stamp    = '0;
	logic [2:0]        set_lvl       = SET_LEVEL_RST;
	logic signed [3:0] cur_lvl       = '0;
	logic              heater        = 1'b0;
	logic [4:0]        bar           = '0;

	in_t  item_queue [$];
	out_t expected_panel [$];
	logic steady = 1'b0;

	int error_count = 0;
	int mismatch_count = 0;
	int request_count = 0;
	int cfg_writes = 0;
	int long_cnt = 0;
	int release_cnt = 0;
	int save_cnt = 0;
	int timeout_cnt = 0;
	int quiet_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// signed 16-bit elapsed time; negative never exceeds
	function automatic logic elapsed_over(input logic [15:0] stamp, input logic [14:0] limit);
		logic signed [15:0] d;
		d = tick_cnt - stamp;
		return d > $signed({1'b0, limit});
	endfunction

	function automatic logic [4:0] lit_mask(input logic [2:0] lvl);
		return 5'((1 << (int'(lvl) + 1)) - 1);
	endfunction

	function automatic void goto_state(input logic [1:0] s);
		mode_pred = s;
		mode_stamp = tick_cnt;
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [14:0] data);
		case (idx)
			REG_THR_A, REG_THR_B, REG_THR_C, REG_THR_D, REG_THR_E: begin
				thr[idx] = data[7:0];
			end
			REG_LONG: begin
				long_ticks = data;
			end
			REG_TIMEOUT: begin
				timeout_ticks = data;
			end
			REG_INIT_LVL: begin
				if (int'(data[2:0]) < LEVEL_COUNT_DEF)
					set_lvl = data[2:0];
			end
			default: ;
		endcase
	endfunction

	function automatic out_t advance_thermostat(input in_t it);
		out_t r;
		logic [1:0] evt;
		logic save;
		logic was;
		logic stop;
		int t;
		int lvl;
		evt = EVT_NONE;
		save = 1'b0;
		if (it.opcode == OP_TICK) begin
			was = (hist_pred != 0);
			tick_cnt = tick_cnt + 16'd1;
			hist_pred = {hist_pred[6:0], it.button_pressed};
			if (hist_pred != 0) begin
				if (!was) begin
					press_stamp = tick_cnt;
					press_latch = EVT_NONE;
				end else if (press_latch == EVT_NONE && elapsed_over(press_stamp, long_ticks)) begin
					press_latch = EVT_LONG;
					evt = EVT_LONG;
				end
			end else if (was && press_latch == EVT_NONE) begin
				press_latch = EVT_RELEASE;
				evt = EVT_RELEASE;
			end

			// bar uses the mode held before this tick
			bar = '0;
			if (mode_pred != DISP_IDLE) begin
				heater = 1'b1;
				if (mode_pred == DISP_SETTING) begin
					if (tick_cnt[BLINK_BIT_DEF])
						bar = lit_mask(set_lvl);
				end else if (!cur_lvl[3]) begin
					bar = lit_mask(cur_lvl[2:0]);
				end
			end

			if (mode_pred != DISP_IDLE && elapsed_over(mode_stamp, timeout_ticks)) begin
				goto_state(DISP_IDLE);
				timeout_cnt++;
			end

			if (evt == EVT_LONG)
				long_cnt++;
			else if (evt == EVT_RELEASE)
				release_cnt++;
			if (evt != EVT_NONE) begin
				if (mode_pred == DISP_SETTING) begin
					if (evt == EVT_RELEASE) begin
						set_lvl = 3'((int'(set_lvl) + 1) % LEVEL_COUNT_DEF);
						goto_state(DISP_SETTING);
					end else begin
						save = 1'b1;
						save_cnt++;
						goto_state(DISP_IDLE);
					end
				end else if (evt == EVT_LONG) begin
					goto_state(DISP_SETTING);
				end else begin
					goto_state(mode_pred == DISP_IDLE ? DISP_MONITOR : DISP_IDLE);
				end
			end
		end else begin
			t = $signed(it.temperature);
			lvl = -1;
			stop = 1'b0;
			for (int i = 0; i < LEVEL_COUNT_DEF; i++) begin
				if (!stop && t >= int'(thr[i < THR_COUNT ? i : THR_COUNT - 1]))
					lvl = i;
				else
					stop = 1'b1;
			end
			cur_lvl = 4'(lvl);
			if (mode_pred == DISP_IDLE)
				heater = (int'(cur_lvl) < int'(set_lvl));
		end
		r.heater_on     = heater;
		r.led_bar       = bar;
		r.ui_mode       = mode_pred;
		r.level_set     = set_lvl;
		r.level_current = cur_lvl;
		r.save_request  = save;
		r.button_event  = evt;
		return r;
	endfunction

	function automatic string panel_str(input out_t v);
		return $sformatf("heat=%0d bar=%b mode=%0d set=%0d cur=%0d save=%0d evt=%0d",
			v.heater_on, v.led_bar, v.ui_mode, v.level_set, $signed(v.level_current),
			v.save_request, v.button_event);
	endfunction

	// driver: holds a stalled request, otherwise sends the next pending item or, at random outside steady phases, idles
	always @(posedge clk) begin : driver
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_panel.push_back(advance_thermostat(in_item));
				void'(item_queue.pop_front());
				request_count++;
			end
			if (!(in_valid && in_stall)) begin
				if (item_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 6)) begin
					in_valid <= 1'b1;
					in_item <= item_queue[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_panel.size() == 0) begin
					error_count++;
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("[%0t] unexpected result: %s", $realtime, panel_str(out_item));
				end else begin
					want = expected_panel.pop_front();
					if (out_item.heater_on !== want.heater_on ||
							out_item.led_bar !== want.led_bar ||
							out_item.ui_mode !== want.ui_mode ||
							out_item.level_set !== want.level_set ||
							out_item.level_current !== want.level_current ||
							out_item.save_request !== want.save_request ||
							out_item.button_event !== want.button_event) begin
						error_count++;
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("[%0t] mismatch: expected %s, got %s", $realtime,
								panel_str(want), panel_str(out_item));
					end
				end
			end
			out_stall <= !steady && ($urandom_range(0, 99) < 6);
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (wr_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("[%0t] no request accepted for %0d cycles, %0d results outstanding",
					$realtime, quiet_cycles, expected_panel.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [14:0] data);
		@(posedge clk);
		wr_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		wr_valid <= 1'b0;
		apply_reg(idx, data);
		cfg_writes++;
	endtask

	// upper data bits are junk the block must ignore
	task automatic set_thresholds(input int a, input int b, input int c, input int d,
			input int e);
		int v [THR_COUNT];
		v = '{a, b, c, d, e};
		for (int k = 0; k < THR_COUNT; k++)
			write_reg(REG_THR_A + 3'(k), {7'($urandom), 8'(v[k])});
	endtask

	task automatic push_tick(input logic b);
		in_t it;
		it.opcode = OP_TICK;
		it.button_pressed = b;
		it.temperature = 8'($urandom);
		item_queue.push_back(it);
	endtask

	task automatic push_temp(input int t);
		in_t it;
		it.opcode = OP_TEMP;
		it.button_pressed = 1'($urandom);
		it.temperature = 8'(t);
		item_queue.push_back(it);
	endtask

	// readings cluster around the thresholds, with extremes and full-range noise
	function automatic int pick_temp();
		int r;
		int t;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			t = int'(thr[$urandom_range(0, THR_COUNT - 1)]) + int'($urandom_range(0, 2)) - 1;
			if (t < -128)
				t = -128;
			if (t > 127)
				t = 127;
		end else if (r == 5) begin
			t = -128;
		end else if (r == 6) begin
			t = 127;
		end else begin
			t = $signed(8'($urandom));
		end
		return t;
	endfunction

	task automatic fill_phase(input int count);
		int r;
		int cap;
		int hold;
		int rel;
		while (item_queue.size() < count) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				// press and release, sometimes bouncing or cut short
				cap = (long_ticks < 24) ? int'(long_ticks) + 6 : 24;
				hold = $urandom_range(1, cap);
				for (int j = 0; j < hold; j++) begin
					push_tick(j == 0 || $urandom_range(0, 19) != 0);
					if ($urandom_range(0, 9) == 0)
						push_temp(pick_temp());
				end
				rel = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 14);
				repeat (rel) push_tick(1'b0);
			end else if (r < 80) begin
				push_temp(pick_temp());
			end else if (r < 90) begin
				repeat ($urandom_range(1, 20)) push_tick(1'b0);
			end else begin
				repeat ($urandom_range(1, 6)) push_tick(1'($urandom));
			end
		end
	endtask

	task automatic drain();
		while (item_queue.size() != 0 || expected_panel.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		int base;
		while (!arst_n)
			@(posedge clk);

		set_thresholds(-10, 0, 10, 20, 30);
		write_reg(REG_LONG, 15'd2);
		write_reg(REG_TIMEOUT, 15'd40);
		write_reg(REG_INIT_LVL, 15'd4);

		// directed: extreme readings, short press into monitor, long press into setting
		push_temp(-128);
		push_temp(127);
		push_temp(9);
		push_tick(1'b1);
		repeat (8) push_tick(1'b0);
		push_temp(25);
		repeat (5) push_tick(1'b1);
		repeat (8) push_tick(1'b0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: begin
					set_thresholds(-128, -128, -128, -128, -128);
					write_reg(REG_LONG, 15'd0);
					write_reg(REG_TIMEOUT, 15'd0);
					write_reg(REG_INIT_LVL, 15'd0);
				end
				2: begin
					set_thresholds(127, 127, 127, 127, 127);
					write_reg(REG_LONG, 15'h7FFF);
					write_reg(REG_TIMEOUT, 15'h7FFF);
					write_reg(REG_INIT_LVL, 15'd7);
				end
				3: begin
					set_thresholds(-128, -64, 0, 64, 127);
					write_reg(REG_LONG, 15'd5);
					write_reg(REG_TIMEOUT, 15'd2000);
					write_reg(REG_INIT_LVL, 15'd5);
				end
				default: begin
					if (p % 2 == 1) begin
						// unordered thresholds
						set_thresholds($signed(8'($urandom)), $signed(8'($urandom)),
							$signed(8'($urandom)), $signed(8'($urandom)), $signed(8'($urandom)));
					end else begin
						base = $urandom_range(0, 60) - 40;
						set_thresholds(base, base + 4, base + 9, base + 15, base + 22);
					end
					write_reg(REG_LONG, 15'($urandom_range(1, 12)));
					write_reg(REG_TIMEOUT, 15'($urandom_range(8, 80)));
					write_reg(REG_INIT_LVL, 15'($urandom_range(0, 7)));
				end
			endcase
			steady = (p == 3);
			fill_phase(PHASE_ITEMS);
			drain();
		end
		steady = 1'b0;

		// monitor mode held under the longest timeout, then a last reading
		write_reg(REG_TIMEOUT, 15'd0);
		repeat (10) push_tick(1'b0);
		drain();
		write_reg(REG_TIMEOUT, 15'h7FFF);
		write_reg(REG_LONG, 15'h7FFF);
		push_tick(1'b1);
		repeat (8) push_tick(1'b0);
		push_temp(15);
		repeat (SOAK_TICKS) push_tick(1'b0);
		push_temp(-50);
		repeat (8) push_tick(1'b0);
		drain();
		repeat (8) @(posedge clk);

		if (expected_panel.size() != 0) begin
			$display("%0d expected results never arrived", expected_panel.size());
			error_count += expected_panel.size();
		end
		$display("Covered %0d requests and %0d register writes over %0d settings",
			request_count, cfg_writes, PHASES + 2);
		$display("Seen %0d long presses, %0d releases, %0d save requests, %0d timeouts",
			long_cnt, release_cnt, save_cnt, timeout_cnt);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
